[hw/rtl/psc_pkg.sv]
// Shared types, constants and helpers for the plane surface classifier.
package psc_pkg;

    localparam int MAX_PLANES = 64;
    localparam int PLANE_AW   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PLANE_CW   = $clog2(MAX_PLANES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] CFG_GRAV_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GRAV_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GRAV_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SPOS_X = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SPOS_Y = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_SPOS_Z = 3'd5;

    // area 2.0 m^2 in Q8.8
    localparam logic [15:0] MIN_AREA = 16'd512;

    // cosine thresholds, scaled by 100 * 2^28
    localparam logic signed [43:0] COS_PAR  = 44'sd25232932864;
    localparam logic signed [43:0] COS_PERP = 44'sd9126805504;

    // distances in mm * 2^14
    localparam logic signed [35:0] HGT_MIN   = 36'sd11468800;
    localparam logic signed [35:0] HGT_MAX   = 36'sd32768000;
    localparam logic signed [35:0] BELOW_MAX = 36'sd1638400;

    typedef enum logic [1:0] {
        KIND_LOAD     = 2'd0,
        KIND_CLEAR    = 2'd1,
        KIND_CLASSIFY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_FLOOR   = 2'd1,
        CLS_CEILING = 2'd2,
        CLS_WALL    = 2'd3
    } surf_cls_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_GDOT,
        F_GSUM,
        F_GCLS,
        F_HDOT,
        F_HCHK,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EXEC,
        B_WALK,
        B_DRAIN
    } back_state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        plane_id;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic [15:0]        area;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  surface_class;
        logic [15:0] floor_id;
        logic        floor_valid;
    } result_t;

    typedef struct packed {
        kind_t              kind;
        logic [15:0]        plane_id;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic               pre_ok;
        surf_cls_t          cls;
        logic               floor_hit;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic signed [35:0] dot_sum(
        input logic signed [33:0] p0,
        input logic signed [33:0] p1,
        input logic signed [33:0] p2
    );
        return 36'(p0) + 36'(p1) + 36'(p2);
    endfunction

endpackage

[hw/rtl/psc_front.sv]
// Front end: config registers, item intake, area, orientation and height checks.
module psc_front
    import psc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  item_t             item,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  q_stat_t           q_stat,
    output logic              busy,
    output logic              q_push,
    output job_t              q_data
);

    front_state_t state_reg, state_next;
    item_t item_reg;
    logic signed [15:0] grav_reg [3];
    logic signed [15:0] spos_reg [3];
    logic signed [33:0] prod_reg [3];
    logic signed [33:0] prod_next [3];
    logic signed [35:0] sum_reg, sum_next;
    logic pre_ok_reg, pre_ok_next;
    surf_cls_t cls_reg, cls_next;
    logic floor_hit_reg, floor_hit_next;
    logic signed [15:0] nvec [3];
    logic signed [15:0] cvec [3];
    logic signed [16:0] mul_a [3];
    logic signed [16:0] mul_b [3];
    logic signed [35:0] prod_sum;
    logic signed [43:0] sum_ext, a100;
    logic accept;

    assign accept = start && (state_reg == F_IDLE);

    assign nvec[0] = item_reg.normal_x;
    assign nvec[1] = item_reg.normal_y;
    assign nvec[2] = item_reg.normal_z;
    assign cvec[0] = item_reg.center_x;
    assign cvec[1] = item_reg.center_y;
    assign cvec[2] = item_reg.center_z;

    assign prod_sum = dot_sum(prod_reg[0], prod_reg[1], prod_reg[2]);
    assign sum_ext  = 44'(sum_reg);
    assign a100     = (sum_ext <<< 6) + (sum_ext <<< 5) + (sum_ext <<< 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                grav_reg[i] <= '0;
                spos_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAV_X: grav_reg[0] <= signed'(cfg_data);
                CFG_GRAV_Y: grav_reg[1] <= signed'(cfg_data);
                CFG_GRAV_Z: grav_reg[2] <= signed'(cfg_data);
                CFG_SPOS_X: spos_reg[0] <= signed'(cfg_data);
                CFG_SPOS_Y: spos_reg[1] <= signed'(cfg_data);
                CFG_SPOS_Z: spos_reg[2] <= signed'(cfg_data);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
        sum_reg       <= sum_next;
        pre_ok_reg    <= pre_ok_next;
        cls_reg       <= cls_next;
        floor_hit_reg <= floor_hit_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start && (item.kind inside {KIND_LOAD, KIND_CLEAR}))
                begin
                    state_next = F_PUSH;
                end
                else if (start && (item.kind == KIND_CLASSIFY))
                begin
                    state_next = F_GDOT;
                end
            end
            F_GDOT:
            begin
                state_next = (item_reg.area < MIN_AREA) ? F_PUSH : F_GSUM;
            end
            F_GSUM: state_next = F_GCLS;
            F_GCLS:
            begin
                state_next = (a100 < -COS_PAR) ? F_HDOT : F_PUSH;
            end
            F_HDOT: state_next = F_HCHK;
            F_HCHK: state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul_a[i] = 17'(nvec[i]);
            mul_b[i] = (state_reg == F_HDOT) ? 17'(spos_reg[i]) - 17'(cvec[i])
                                             : 17'(grav_reg[i]);
            prod_next[i] = (state_reg inside {F_GDOT, F_HDOT})
                           ? 34'(mul_a[i]) * 34'(mul_b[i]) : prod_reg[i];
        end
        sum_next       = (state_reg == F_GSUM) ? prod_sum : sum_reg;
        pre_ok_next    = pre_ok_reg;
        cls_next       = cls_reg;
        floor_hit_next = floor_hit_reg;
        case (state_reg)
            F_IDLE:
            begin
                pre_ok_next    = 1'b1;
                cls_next       = CLS_NONE;
                floor_hit_next = 1'b0;
            end
            F_GDOT:
            begin
                if (item_reg.area < MIN_AREA)
                begin
                    pre_ok_next = 1'b0;
                end
            end
            F_GCLS:
            begin
                if (a100 < -COS_PAR)
                begin
                    cls_next = CLS_FLOOR;
                end
                else if (a100 > COS_PAR)
                begin
                    cls_next = CLS_CEILING;
                end
                else if ((a100 < COS_PERP) && (a100 > -COS_PERP))
                begin
                    cls_next = CLS_WALL;
                end
                else
                begin
                    pre_ok_next = 1'b0;
                end
            end
            F_HCHK:
            begin
                if ((prod_sum < HGT_MIN) || (prod_sum > HGT_MAX))
                begin
                    pre_ok_next = 1'b0;
                    cls_next    = CLS_NONE;
                end
                else
                begin
                    floor_hit_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        busy             = (state_reg != F_IDLE);
        q_push           = (state_reg == F_PUSH) && !q_stat.full;
        q_data.kind      = kind_t'(item_reg.kind);
        q_data.plane_id  = item_reg.plane_id;
        q_data.normal_x  = item_reg.normal_x;
        q_data.normal_y  = item_reg.normal_y;
        q_data.normal_z  = item_reg.normal_z;
        q_data.center_x  = item_reg.center_x;
        q_data.center_y  = item_reg.center_y;
        q_data.center_z  = item_reg.center_z;
        q_data.pre_ok    = pre_ok_reg;
        q_data.cls       = cls_reg;
        q_data.floor_hit = floor_hit_reg;
    end

endmodule

[hw/rtl/psc_queue.sv]
// Short job queue between the front end and the back end.
module psc_queue
    import psc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_data,
    input  logic    pop,
    output job_t    pop_data,
    output q_stat_t stat
);

    job_t slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

[hw/rtl/psc_back.sv]
// Back end: plane store, load and clear, map check walk and result register.
module psc_back
    import psc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_stat_t q_stat,
    input  job_t    q_data,
    output logic    q_pop,
    output logic    done,
    output result_t result
);

    back_state_t state_reg, state_next;
    job_t job_reg;
    logic [PLANE_CW-1:0] count_reg, count_next;
    logic [PLANE_CW-1:0] rd_idx_reg, rd_idx_next;
    logic [15:0] floor_id_reg, floor_id_next;
    logic floor_seen_reg, floor_seen_next;
    logic s1_v_reg, s1_v_next;
    logic s2_v_reg, s2_v_next;
    logic s2_skip_reg;
    logic signed [33:0] prod_reg [3];
    logic pass_reg, pass_next;
    logic done_reg, done_next;
    result_t result_reg, result_next;
    logic [63:0] mem [MAX_PLANES];
    logic [63:0] mem_q;
    logic mem_we, rd_en, emit, emit_ok;
    logic [63:0] mem_wdata;
    logic signed [15:0] nvec [3];
    logic signed [15:0] cvec [3];
    logic signed [15:0] evec [3];
    logic signed [16:0] diff [3];
    logic signed [35:0] below;

    assign nvec[0] = job_reg.normal_x;
    assign nvec[1] = job_reg.normal_y;
    assign nvec[2] = job_reg.normal_z;
    assign cvec[0] = job_reg.center_x;
    assign cvec[1] = job_reg.center_y;
    assign cvec[2] = job_reg.center_z;
    assign evec[0] = signed'(mem_q[31:16]);
    assign evec[1] = signed'(mem_q[47:32]);
    assign evec[2] = signed'(mem_q[63:48]);

    assign mem_wdata = {job_reg.center_z, job_reg.center_y, job_reg.center_x, job_reg.plane_id};
    assign below     = dot_sum(prod_reg[0], prod_reg[1], prod_reg[2]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[PLANE_AW-1:0]] <= mem_wdata;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_idx_reg[PLANE_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (s1_v_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= 34'(17'(nvec[i])) * 34'(diff[i]);
            end
            s2_skip_reg <= (mem_q[15:0] == job_reg.plane_id);
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            floor_id_reg   <= '0;
            floor_seen_reg <= 1'b0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            pass_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            floor_id_reg   <= floor_id_next;
            floor_seen_reg <= floor_seen_next;
            s1_v_reg       <= s1_v_next;
            s2_v_reg       <= s2_v_next;
            pass_reg       <= pass_next;
            done_reg       <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if ((job_reg.kind == KIND_CLASSIFY) && job_reg.pre_ok)
                begin
                    state_next = B_WALK;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_WALK:
            begin
                if (rd_idx_reg >= count_reg)
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop           = (state_reg == B_IDLE) && !q_stat.empty;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        emit            = 1'b0;
        emit_ok         = 1'b0;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        floor_id_next   = floor_id_reg;
        floor_seen_next = floor_seen_reg;
        pass_next       = pass_reg;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = 17'(evec[i]) - 17'(cvec[i]);
        end
        case (state_reg)
            B_EXEC:
            begin
                case (job_reg.kind)
                    KIND_LOAD:
                    begin
                        if (count_reg < PLANE_CW'(MAX_PLANES))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        count_next = '0;
                    end
                    KIND_CLASSIFY:
                    begin
                        if (job_reg.floor_hit)
                        begin
                            floor_id_next   = job_reg.plane_id;
                            floor_seen_next = 1'b1;
                        end
                        pass_next   = 1'b1;
                        rd_idx_next = '0;
                        emit        = !job_reg.pre_ok;
                    end
                    default: ;
                endcase
            end
            B_WALK:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            B_DRAIN:
            begin
                emit    = !s1_v_reg && !s2_v_reg;
                emit_ok = pass_reg;
            end
            default: ;
        endcase
        if (s2_v_reg && !s2_skip_reg && (below < -BELOW_MAX))
        begin
            pass_next = 1'b0;
        end
        s1_v_next = rd_en;
        s2_v_next = s1_v_reg;
        done_next = emit;
        result_next.accepted      = emit_ok;
        result_next.surface_class = emit_ok ? job_reg.cls : CLS_NONE;
        result_next.floor_id      = floor_id_next;
        result_next.floor_valid   = floor_seen_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hw/rtl/plane_surface_classifier_top.sv]
// Top level of the plane surface classifier: front end, job queue, back end.
//
//  channel   signals                          beat taken when
//  -------   -------------------------------  ----------------------------
//  input     start, busy, item                start high and busy low
//  result    done, result                     done high (one cycle, no stall)
//  config    cfg_we, cfg_index, cfg_data      cfg_we high
//
//  Load and clear: the front end stays busy with each item until the queue has room to take it.
//  Classify: the front end checks the area and forms the gravity dot product, sets the
//  orientation class and, for a floor candidate, checks the height, then pushes the job; the
//  back end reports a plane that the front end rejected without a walk, else walks the store,
//  reading one store entry per cycle through its single read port, and drains the check
//  pipeline before it shows the result beat.
//  Reset clears control state and all config registers; store contents are not cleared.
//  The receiver cannot stall: each result beat is shown for exactly one cycle.
module plane_surface_classifier_top
    import psc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    q_stat_t q_stat;
    logic    q_push, q_pop;
    job_t    q_push_data, q_pop_data;

    psc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .busy      (busy),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    psc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    psc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (q_pop_data),
        .q_pop  (q_pop),
        .done   (done),
        .result (result)
    );

endmodule

[hw/rtl/psc_checker.sv]
// Port-level checks for the plane surface classifier, bound to the top level.
module psc_checker
    import psc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    done,
    input result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.accepted |-> result.surface_class == CLS_NONE)
        else $error("rejected beat carries a surface class");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.accepted && (result.surface_class == CLS_FLOOR) |-> result.floor_valid)
        else $error("floor beat without floor record");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.kind == KIND_LOAD || item.kind == KIND_CLEAR ||
                           item.kind == KIND_CLASSIFY) |=> busy)
        else $error("front end did not hold busy after taking a beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats back to back");

endmodule

bind plane_surface_classifier_top psc_checker u_psc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

[tb/sv/plane_surface_classifier_checker.sv]
// Checker for the plane surface classifier: predicts each classify beat and compares results.
module plane_surface_classifier_checker
    import psc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  item_t             item,
    input  logic              done,
    input  result_t           result,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          REG_COUNT      = int'(CFG_SPOS_Z) + 1;
    localparam logic [15:0] AREA_MIN       = 16'd512;
    localparam longint      COS_NEAR_AXIS  = 94 * 64'sd268435456;
    localparam longint      COS_NEAR_FLAT  = 34 * 64'sd268435456;
    localparam longint      HEIGHT_LO      = 700 * 64'sd16384;
    localparam longint      HEIGHT_HI      = 2000 * 64'sd16384;
    localparam longint      BELOW_LIMIT    = 100 * 64'sd16384;
    localparam int          PRINT_LIMIT    = 40;

    logic [15:0]       plane_store_id  [MAX_PLANES];
    longint            plane_store_ctr [MAX_PLANES][3];
    int                plane_count;
    logic [15:0]       floor_reg;
    logic              floor_seen;
    logic [CFG_DW-1:0] cfg_reg [REG_COUNT];
    result_t           verdict_q [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic bit plane_verdict(input item_t it, output result_t v);
        longint    n [3];
        longint    c [3];
        longint    g [3];
        longint    s [3];
        longint    cosv;
        longint    h;
        longint    d;
        bit        ok;
        surf_cls_t cls;
        v = '0;
        c[0] = it.center_x;
        c[1] = it.center_y;
        c[2] = it.center_z;
        case (it.kind)
            KIND_LOAD:
            begin
                if (plane_count < MAX_PLANES)
                begin
                    plane_store_id[plane_count] = it.plane_id;
                    for (int a = 0; a < 3; a++)
                        plane_store_ctr[plane_count][a] = c[a];
                    plane_count++;
                end
                return 1'b0;
            end
            KIND_CLEAR:
            begin
                plane_count = 0;
                return 1'b0;
            end
            KIND_CLASSIFY: ;
            default: return 1'b0;
        endcase
        n[0] = it.normal_x;
        n[1] = it.normal_y;
        n[2] = it.normal_z;
        g[0] = $signed(cfg_reg[CFG_GRAV_X]);
        g[1] = $signed(cfg_reg[CFG_GRAV_Y]);
        g[2] = $signed(cfg_reg[CFG_GRAV_Z]);
        s[0] = $signed(cfg_reg[CFG_SPOS_X]);
        s[1] = $signed(cfg_reg[CFG_SPOS_Y]);
        s[2] = $signed(cfg_reg[CFG_SPOS_Z]);
        ok  = 1'b1;
        cls = CLS_NONE;
        if (it.area < AREA_MIN)
        begin
            ok = 1'b0;
        end
        else
        begin
            cosv = 100 * (g[0] * n[0] + g[1] * n[1] + g[2] * n[2]);
            if (cosv < -COS_NEAR_AXIS)
            begin
                h = n[0] * (s[0] - c[0]) + n[1] * (s[1] - c[1]) + n[2] * (s[2] - c[2]);
                if (h < HEIGHT_LO || h > HEIGHT_HI)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    floor_reg  = it.plane_id;
                    floor_seen = 1'b1;
                    cls        = CLS_FLOOR;
                end
            end
            else if (cosv > COS_NEAR_AXIS)
                cls = CLS_CEILING;
            else if (cosv < COS_NEAR_FLAT && cosv > -COS_NEAR_FLAT)
                cls = CLS_WALL;
            else
                ok = 1'b0;
        end
        if (ok)
        begin
            for (int i = 0; i < plane_count; i++)
            begin
                if (plane_store_id[i] == it.plane_id)
                    continue;
                d = n[0] * (plane_store_ctr[i][0] - c[0])
                  + n[1] * (plane_store_ctr[i][1] - c[1])
                  + n[2] * (plane_store_ctr[i][2] - c[2]);
                if (d < -BELOW_LIMIT)
                begin
                    ok = 1'b0;
                    break;
                end
            end
        end
        v.accepted      = ok;
        v.surface_class = ok ? cls : CLS_NONE;
        v.floor_id      = floor_reg;
        v.floor_valid   = floor_seen;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            plane_count = 0;
            floor_reg   = '0;
            floor_seen  = 1'b0;
            for (int r = 0; r < REG_COUNT; r++)
                cfg_reg[r] = '0;
            verdict_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", result, 0);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.accepted !== want.accepted)
                        report_mismatch("accepted", result.accepted, want.accepted);
                    if (result.surface_class !== want.surface_class)
                        report_mismatch("surface_class", result.surface_class,
                                        want.surface_class);
                    if (result.floor_id !== want.floor_id)
                        report_mismatch("floor_id", result.floor_id, want.floor_id);
                    if (result.floor_valid !== want.floor_valid)
                        report_mismatch("floor_valid", result.floor_valid, want.floor_valid);
                end
            end
            if (cfg_we && cfg_index <= CFG_SPOS_Z)
                cfg_reg[cfg_index] = cfg_data;
            if (start && !busy)
            begin
                if (plane_verdict(item, want))
                    verdict_q.insert(verdict_q.size(), want);
            end
            pending = verdict_q.size();
        end
    end

endmodule

[tb/sv/plane_surface_classifier_top_tb.sv]
// Testbench top for the plane surface classifier: clock, reset, stimulus and verdict.
module plane_surface_classifier_top_tb
    import psc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEMS_TOTAL   = 1600;
    localparam int          PHASES        = 10;
    localparam int          PER_PHASE     = ITEMS_TOTAL / PHASES;
    localparam int          CYCLE_LIMIT   = 2000000;
    localparam int          SETTLE_CYCLES = 100;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    typedef enum int {
        AIM_FLOOR,
        AIM_CEILING,
        AIM_WALL,
        AIM_ANY
    } aim_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    item_t             item;
    logic              done;
    result_t           result;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                cycle_count;

    int grav [3];
    int spos [3];
    int up_axis;
    int sent;
    bit idle_on;

    plane_surface_classifier_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plane_surface_classifier_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("plane_surface_classifier_top_tb NOT OK");
            $finish;
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return int'($urandom_range(0, hi - lo)) + lo;
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = rand_between(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return rand_between(1, 3);
        return rand_between(4, 40);
    endfunction

    function automatic logic [15:0] pick_area();
        case ($urandom_range(0, 9))
            0: return 16'(rand_between(0, 511));
            1: return 16'(rand_between(509, 515));
            2: return 16'($urandom);
            default: return 16'(rand_between(512, 4000));
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 4) < 3)
            return 16'(rand_between(0, 7));
        return 16'($urandom);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item  = it;
        start = 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
        if (it.kind != KIND_UNUSED)
            sent++;
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [15:0] id,
                               input logic [15:0] nx, input logic [15:0] ny,
                               input logic [15:0] nz, input logic [15:0] cx,
                               input logic [15:0] cy, input logic [15:0] cz,
                               input logic [15:0] area);
        item_t it;
        it.kind     = kind;
        it.plane_id = id;
        it.normal_x = nx;
        it.normal_y = ny;
        it.normal_z = nz;
        it.center_x = cx;
        it.center_y = cy;
        it.center_z = cz;
        it.area     = area;
        send_item(it);
    endtask

    task automatic send_load();
        send_fields(KIND_LOAD, pick_id(), 16'($urandom), 16'($urandom), 16'($urandom),
                    clamp16(spos[0] + rand_between(-3000, 3000)),
                    clamp16(spos[1] + rand_between(-3000, 3000)),
                    clamp16(spos[2] + rand_between(-3000, 3000)), 16'($urandom));
    endtask

    task automatic send_noise();
        send_fields(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
    endtask

    task automatic send_classify(input aim_t aim);
        longint n [3];
        longint c [3];
        longint rest;
        longint h_mm;
        for (int a = 0; a < 3; a++)
        begin
            case (aim)
                AIM_FLOOR:   n[a] = -grav[a];
                AIM_CEILING: n[a] = grav[a];
                default:     n[a] = rand_between(-16384, 16384);
            endcase
            c[a] = spos[a] + rand_between(-3000, 3000);
        end
        if (aim == AIM_WALL)
            n[up_axis] = rand_between(-6500, 6500);
        if ((aim == AIM_FLOOR || aim == AIM_CEILING) && $urandom_range(0, 2) != 0)
        begin
            for (int a = 0; a < 3; a++)
                n[a] += rand_between(-700, 700);
        end
        if (aim == AIM_FLOOR && n[up_axis] != 0)
        begin
            case ($urandom_range(0, 5))
                0: h_mm = 700;
                1: h_mm = 2000;
                2: h_mm = 699;
                3: h_mm = 2001;
                default: h_mm = rand_between(500, 2300);
            endcase
            rest = 0;
            for (int a = 0; a < 3; a++)
            begin
                if (a != up_axis)
                    rest += n[a] * (spos[a] - c[a]);
            end
            c[up_axis] = spos[up_axis] - (h_mm * 16384 - rest) / n[up_axis];
        end
        send_fields(KIND_CLASSIFY, pick_id(), clamp16(n[0]), clamp16(n[1]), clamp16(n[2]),
                    clamp16(c[0]), clamp16(c[1]), clamp16(c[2]), pick_area());
    endtask

    task automatic wait_results();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[15:0];
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_config(input int p);
        int sgn;
        up_axis = rand_between(0, 2);
        sgn     = $urandom_range(0, 1) ? 1 : -1;
        for (int a = 0; a < 3; a++)
        begin
            grav[a] = 0;
            spos[a] = rand_between(-3000, 3000);
        end
        grav[up_axis] = sgn * 16384;
        case (p)
            0:
            begin
                up_axis = 2;
                grav    = '{0, 0, 16384};
                spos    = '{0, 0, 0};
            end
            2:
            begin
                up_axis = 0;
                grav    = '{-16384, 0, 0};
                spos    = '{32767, -32768, 32767};
            end
            3, 6:
            begin
                for (int a = 0; a < 3; a++)
                    grav[a] = rand_between(-2500, 2500);
                grav[up_axis] = sgn * rand_between(15200, 16384);
            end
            7: spos = '{-32768, 32767, -32768};
            8:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    grav[a] = rand_between(-32768, 32767);
                    spos[a] = rand_between(-32768, 32767);
                end
            end
            default: ;
        endcase
        write_reg(CFG_GRAV_X, grav[0]);
        write_reg(CFG_GRAV_Y, grav[1]);
        write_reg(CFG_GRAV_Z, grav[2]);
        write_reg(CFG_SPOS_X, spos[0]);
        write_reg(CFG_SPOS_Y, spos[1]);
        write_reg(CFG_SPOS_Z, spos[2]);
    endtask

    task automatic run_directed();
        send_fields(KIND_CLASSIFY, 16'd5, 0, 0, -16'sd16384, 0, 0, 700, 16'd511);
        send_fields(KIND_CLASSIFY, 16'd5, 0, 0, -16'sd16384, 0, 0, 700, 16'd512);
        send_fields(KIND_CLASSIFY, 16'd6, 0, 0, -16'sd16384, 0, 0, 699, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd7, 0, 0, -16'sd16384, 0, 0, 2000, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd8, 0, 0, -16'sd16384, 0, 0, 2001, 16'd600);
        send_fields(KIND_CLASSIFY, 16'hFFFF, 0, 0, 16384, 0, 0, 0, 16'hFFFF);
        send_fields(KIND_CLASSIFY, 16'd4, 16384, 0, 0, 0, 0, 0, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd4, 0, 0, 15401, 0, 0, 0, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd4, 0, 0, 15400, 0, 0, 0, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd4, 16384, 0, 5570, 0, 0, 0, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd4, 16384, 0, 5571, 0, 0, 0, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd11, 0, 0, -16'sd15401, 0, 0, 1000, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd12, 0, 0, -16'sd15400, 0, 0, 1000, 16'd600);
        send_fields(KIND_LOAD, 16'd1, 0, 0, 0, 0, 0, 0, 0);
        send_fields(KIND_LOAD, 16'd2, 0, 0, 0, 0, 0, 5000, 0);
        send_fields(KIND_CLASSIFY, 16'd3, 0, 0, 16384, 0, 0, 100, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd3, 0, 0, 16384, 0, 0, 101, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd1, 0, 0, 16384, 0, 0, 200, 16'd600);
        send_fields(KIND_CLASSIFY, 16'd9, 0, 0, -16'sd16384, 0, 0, 700, 16'd600);
        send_fields(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        send_fields(KIND_CLASSIFY, 16'd10, 0, 0, -16'sd16384, 0, 0, 700, 16'd600);
        send_fields(KIND_LOAD, 16'hFFFF, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h8000, 0);
        send_fields(KIND_CLASSIFY, 16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                    16'h8000, 16'h7FFF, 16'hFFFF);
        send_fields(KIND_CLASSIFY, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                    16'h7FFF, 16'h8000, 16'd512);
    endtask

    initial
    begin
        int r;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sent      = 0;
        idle_on   = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            apply_config(p);
            idle_on = (p % 4 != 3);
            if (p == 0)
                run_directed();
            if (p == 1)
            begin
                send_fields(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
                repeat (MAX_PLANES + 4) send_load();
                repeat (3) send_classify(aim_t'($urandom_range(0, 3)));
            end
            while (sent < (p + 1) * PER_PHASE)
            begin
                r = rand_between(0, 99);
                if (r < 55)
                begin
                    if ($urandom_range(0, 9) < 7)
                        send_fields(KIND_CLEAR, pick_id(), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
                    if ($urandom_range(0, 19) == 0)
                        repeat (rand_between(60, 70)) send_load();
                    else
                        repeat (rand_between(0, 4)) send_load();
                    repeat (rand_between(1, 4)) send_classify(aim_t'($urandom_range(0, 3)));
                end
                else if (r < 75)
                    send_classify(aim_t'($urandom_range(0, 3)));
                else if (r < 85)
                    repeat (rand_between(1, 3)) send_load();
                else if (r < 96)
                    send_noise();
                else
                    wait_results();
            end
        end
        settle();
        if (fail_count == 0)
            $display("plane_surface_classifier_top_tb OK");
        else
            $display("plane_surface_classifier_top_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/psc_pkg.sv
hw/rtl/psc_front.sv
hw/rtl/psc_queue.sv
hw/rtl/psc_back.sv
hw/rtl/plane_surface_classifier_top.sv
hw/rtl/psc_checker.sv
tb/sv/plane_surface_classifier_checker.sv
tb/sv/plane_surface_classifier_top_tb.sv
